/* rtl/hmt_pkg.sv */
// ----------------------------------------------------------------------------
// hmt_pkg
// Shared widths, record kinds and the triangle job type for the heightmap
// mesh triangulator.
// ----------------------------------------------------------------------------
package hmt_pkg;

  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 1024;

  localparam int HW  = 24;  // height sample width
  localparam int CW  = 40;  // output coordinate width
  localparam int TW  = 22;  // triangle count width
  localparam int PW  = 13;  // grid position width (up to 4096 plus one)
  localparam int SZW = 11;  // size register width

  localparam logic signed [HW-1:0] DROP_LIMIT = -24'sd12800;

  localparam logic [1:0] KIND_NORMAL = 2'd0;
  localparam logic [1:0] KIND_VERTEX = 2'd1;
  localparam logic [1:0] KIND_COUNT  = 2'd2;

  localparam logic [0:0] REG_WIDTH  = 1'b0;
  localparam logic [0:0] REG_HEIGHT = 1'b1;

  // one vertex: grid column, grid row, height
  typedef struct packed {
    logic signed [PW:0]   x;
    logic signed [PW:0]   y;
    logic signed [HW-1:0] z;
  } vtx_t;

  // one job handed from front to back: a triangle or the count record
  typedef struct packed {
    logic          is_count;
    logic [TW-1:0] count;
    vtx_t          a;
    vtx_t          b;
    vtx_t          c;
    logic          last;
  } job_t;

endpackage

/* rtl/heightmap_mesh_triangulator.sv */
// Throughput: one record per cycle at best, while out_ready is high; each triangle
// gives four records, its normal and then its three vertices, and the multiply and
// subtract states before them load no record.
// The front takes the next sample once the current one's jobs are queued.
// Reset (synchronous, rst high) sets both sizes to 40 and starts a new frame;
// the row memory is not cleared, row 0 always writes before it is read.
// ----------------------------------------------------------------------------
// heightmap_mesh_triangulator
// Grid height samples in, surface, wall and base triangles out.
// ----------------------------------------------------------------------------
module heightmap_mesh_triangulator import hmt_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic                 cfg_idx,
  input  logic [SZW-1:0]       cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic signed [HW-1:0] height,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [1:0]           record_kind,
  output logic signed [CW-1:0] coord_x,
  output logic signed [CW-1:0] coord_y,
  output logic signed [CW-1:0] coord_z,
  output logic                 last
);

  logic f_valid, f_ready, q_valid, q_ready;
  job_t f_job, q_job;

  // front: sample intake and job list
  hmt_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_front (
    .clk, .rst, .cfg_we, .cfg_idx, .cfg_data,
    .in_valid, .in_ready, .height,
    .job_valid(f_valid), .job_ready(f_ready), .job(f_job)
  );

  // job queue
  hmt_queue #(.DEPTH(4)) u_queue (
    .clk, .rst,
    .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_job),
    .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_job)
  );

  // back: normals and records
  hmt_back u_back (
    .clk, .rst,
    .job_valid(q_valid), .job_ready(q_ready), .job(q_job),
    .out_valid, .ready(out_ready), .record_kind,
    .coord_x, .coord_y, .coord_z, .last
  );

endmodule

/* rtl/hmt_front.sv */
// ----------------------------------------------------------------------------
// hmt_front
// Accepts samples, keeps the previous row and splits each sample into a list of
// triangle jobs and a count job at frame end, one job per cycle while job_ready is high.
// ----------------------------------------------------------------------------
module hmt_front import hmt_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic                 cfg_idx,
  input  logic [SZW-1:0]       cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic signed [HW-1:0] height,
  output logic                 job_valid,
  input  logic                 job_ready,
  output job_t                 job
);

  localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

  // job slots in emission order
  localparam int NSLOT    = 11;
  localparam logic [3:0] S_LOWER  = 4'd0;
  localparam logic [3:0] S_FW0    = 4'd1;
  localparam logic [3:0] S_FW1    = 4'd2;
  localparam logic [3:0] S_UPPER  = 4'd3;
  localparam logic [3:0] S_BW0    = 4'd4;
  localparam logic [3:0] S_BW1    = 4'd5;
  localparam logic [3:0] S_SIDE0  = 4'd6;
  localparam logic [3:0] S_SIDE1  = 4'd7;
  localparam logic [3:0] S_BASE0  = 4'd8;
  localparam logic [3:0] S_BASE1  = 4'd9;
  localparam logic [3:0] S_CNT    = 4'd10;

  // size registers
  logic [SZW-1:0] grid_width;
  logic [SZW-1:0] grid_height;
  logic [PW-1:0]  w, hg;

  always_comb begin
    if (grid_width < SZW'(2)) w = PW'(2);
    else if (PW'(grid_width) > PW'(MAX_WIDTH)) w = PW'(MAX_WIDTH);
    else w = PW'(grid_width);
    if (grid_height < SZW'(2)) hg = PW'(2);
    else if (PW'(grid_height) > PW'(MAX_HEIGHT)) hg = PW'(MAX_HEIGHT);
    else hg = PW'(grid_height);
  end

  // previous row memory, two read ports (column and column + 1)
  logic signed [HW-1:0] row_store [MAX_WIDTH];
  logic signed [HW-1:0] up, upr;

  // frame position and counters
  logic [PW-1:0]        column, row;
  logic signed [HW-1:0] left_sample;
  logic [TW-1:0]        triangle_total;

  // stage registers: sample being expanded
  logic                 busy, rd_pend;
  logic signed [HW-1:0] cur_h, cur_left;
  logic [PW-1:0]        cur_c, cur_r;
  logic [NSLOT-1:0]     pend;
  logic [TW-1:0]        cur_total;

  logic [PW-1:0] col_cl, row_cl;
  always_comb begin
    col_cl = (column >= w) ? w - PW'(1) : column;
    row_cl = (row >= hg) ? hg - PW'(1) : row;
  end

  logic accept;
  assign in_ready = !busy;
  assign accept   = in_valid && in_ready;

  logic [AW-1:0] rd_a0, rd_a1;
  assign rd_a0 = col_cl[AW-1:0];
  assign rd_a1 = (col_cl + PW'(1) < w) ? rd_a0 + AW'(1) : rd_a0;

  always_ff @(posedge clk) begin
    if (accept) begin
      up  <= row_store[rd_a0];
      upr <= row_store[rd_a1];
      row_store[rd_a0] <= height;
    end
  end

  // slot enables, evaluated once the stored row is read
  logic [NSLOT-1:0] en;
  logic k_h, k_up, k_upr, k_l, lower_ok, upper_ok, side_ok, fin;
  always_comb begin
    k_h   = cur_h > DROP_LIMIT;
    k_up  = up > DROP_LIMIT;
    k_upr = upr > DROP_LIMIT;
    k_l   = cur_left > DROP_LIMIT;
    fin   = (cur_r == hg - PW'(1)) && (cur_c == w - PW'(1));
    lower_ok = (cur_r != '0) && (cur_c + PW'(1) < w) && k_upr && k_up && k_h;
    upper_ok = (cur_r != '0) && (cur_c != '0) && k_h && k_up && k_l;
    side_ok  = (cur_r != '0) && k_h && k_up &&
               ((cur_c == '0) || (cur_c == w - PW'(1)));
    en = '0;
    en[S_LOWER] = lower_ok;
    en[S_FW0]   = lower_ok && (cur_r == PW'(1));
    en[S_FW1]   = en[S_FW0];
    en[S_UPPER] = upper_ok;
    en[S_BW0]   = upper_ok && (cur_r == hg - PW'(1));
    en[S_BW1]   = en[S_BW0];
    en[S_SIDE0] = side_ok;
    en[S_SIDE1] = side_ok;
    en[S_BASE0] = fin;
    en[S_BASE1] = fin;
    en[S_CNT]   = fin;
  end

  // lowest pending slot
  logic [3:0]       slot;
  logic             any;
  logic [NSLOT-1:0] rest;
  always_comb begin
    slot = '0;
    any  = 1'b0;
    for (int i = NSLOT - 1; i >= 0; i--) begin
      if (pend[i]) begin
        slot = 4'(i);
        any  = 1'b1;
      end
    end
    rest = pend;
    rest[slot] = 1'b0;
  end

  // vertex builders
  function automatic vtx_t mkv(logic [PW-1:0] x, logic [PW-1:0] y,
                               logic signed [HW-1:0] z);
    vtx_t v;
    v.x = $signed({1'b0, x});
    v.y = $signed({1'b0, y});
    v.z = z;
    return v;
  endfunction

  logic [PW-1:0] c1, cm1, rm1;
  vtx_t va, vb, vc;
  always_comb begin
    c1  = cur_c + PW'(1);
    cm1 = cur_c - PW'(1);
    rm1 = cur_r - PW'(1);
    va = mkv(c1, rm1, upr);
    vb = va;
    vc = va;
    case (slot)
      S_LOWER: begin
        va = mkv(c1, rm1, upr); vb = mkv(cur_c, cur_r, cur_h); vc = mkv(cur_c, rm1, up);
      end
      S_FW0: begin
        va = mkv(cur_c, rm1, up); vb = mkv(cur_c, '0, '0); vc = mkv(c1, rm1, upr);
      end
      S_FW1: begin
        va = mkv(c1, '0, '0); vb = mkv(c1, rm1, upr); vc = mkv(cur_c, '0, '0);
      end
      S_UPPER: begin
        va = mkv(cur_c, cur_r, cur_h); vb = mkv(cm1, cur_r, cur_left);
        vc = mkv(cur_c, rm1, up);
      end
      S_BW0: begin
        va = mkv(cm1, cur_r, cur_left); vb = mkv(cur_c, cur_r, cur_h);
        vc = mkv(cm1, cur_r, '0);
      end
      S_BW1: begin
        va = mkv(cur_c, cur_r, '0); vb = mkv(cm1, cur_r, '0); vc = mkv(cur_c, cur_r, cur_h);
      end
      S_SIDE0: begin
        if (cur_c == '0) begin
          va = mkv(cur_c, rm1, '0); vb = mkv(cur_c, rm1, up); vc = mkv(cur_c, cur_r, cur_h);
        end else begin
          va = mkv(cur_c, rm1, up); vb = mkv(cur_c, rm1, '0); vc = mkv(cur_c, cur_r, cur_h);
        end
      end
      S_SIDE1: begin
        if (cur_c == '0) begin
          va = mkv(cur_c, cur_r, cur_h); vb = mkv(cur_c, cur_r, '0); vc = mkv(cur_c, rm1, '0);
        end else begin
          va = mkv(cur_c, cur_r, '0); vb = mkv(cur_c, cur_r, cur_h); vc = mkv(cur_c, rm1, '0);
        end
      end
      S_BASE0: begin
        va = mkv('0, '0, '0); vb = mkv(cur_c, cur_r, '0); vc = mkv(cur_c, '0, '0);
      end
      S_BASE1: begin
        va = mkv('0, '0, '0); vb = mkv('0, cur_r, '0); vc = mkv(cur_c, cur_r, '0);
      end
      default: begin
        va = mkv('0, '0, '0); vb = va; vc = va;
      end
    endcase
    job.is_count = (slot == S_CNT);
    job.count    = cur_total;
    job.a        = va;
    job.b        = vb;
    job.c        = vc;
    job.last     = (rest == '0);
  end

  assign job_valid = busy && !rd_pend && any;

  logic fire;
  assign fire = job_valid && job_ready;

  // sequencing of the sample stage and frame position
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width     <= SZW'(40);
      grid_height    <= SZW'(40);
      column         <= '0;
      row            <= '0;
      left_sample    <= '0;
      triangle_total <= '0;
      busy           <= 1'b0;
      rd_pend        <= 1'b0;
      pend           <= '0;
    end else if (cfg_we) begin
      if (cfg_idx == REG_WIDTH) grid_width <= cfg_data;
      else grid_height <= cfg_data;
      column         <= '0;
      row            <= '0;
      left_sample    <= '0;
      triangle_total <= '0;
    end else begin
      if (accept) begin
        busy     <= 1'b1;
        rd_pend  <= 1'b1;
        cur_h    <= height;
        cur_left <= left_sample;
        cur_c    <= col_cl;
        cur_r    <= row_cl;
        left_sample <= height;
        if ((row_cl == hg - PW'(1)) && (col_cl == w - PW'(1))) begin
          column <= '0;
          row    <= '0;
        end else if (col_cl + PW'(1) >= w) begin
          column <= '0;
          row    <= row_cl + PW'(1);
        end else begin
          column <= col_cl + PW'(1);
          row    <= row_cl;
        end
      end else if (rd_pend) begin
        rd_pend <= 1'b0;
        pend    <= en;
        if (en == '0) busy <= 1'b0;
        // count the triangles of this sample ahead of the count record
        cur_total <= triangle_total + TW'($countones(en[S_BASE1:S_LOWER]));
        if (fin) triangle_total <= '0;
        else triangle_total <= triangle_total + TW'($countones(en[S_BASE1:S_LOWER]));
      end else if (fire) begin
        pend <= rest;
        if (rest == '0) busy <= 1'b0;
      end
    end
  end

  // a job is only offered while the sample stage holds one
  a_job_busy: assert property (@(posedge clk) disable iff (rst) job_valid |-> busy)
    else $error("job offered with no sample held");
  // no new sample while the current one still has jobs
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    (busy && pend != '0) |-> !in_ready)
    else $error("sample accepted while jobs pending");
  // the count record always closes a sample
  a_cnt_last: assert property (@(posedge clk) disable iff (rst)
    (job_valid && job.is_count) |-> job.last)
    else $error("count record not last");

endmodule

/* rtl/hmt_queue.sv */
// ----------------------------------------------------------------------------
// hmt_queue
// Short job queue between the front and back parts.
// ----------------------------------------------------------------------------
module hmt_queue import hmt_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic clk,
  input  logic rst,
  input  logic wr_valid,
  output logic wr_ready,
  input  job_t wr_data,
  output logic rd_valid,
  input  logic rd_ready,
  output job_t rd_data
);

  localparam int AW = $clog2(DEPTH);

  job_t          mem [DEPTH];
  logic [AW-1:0] wp, rp;
  logic [AW:0]   cnt;

  assign wr_ready = cnt != (AW+1)'(DEPTH);
  assign rd_valid = cnt != '0;
  assign rd_data  = mem[rp];

  logic wr, rd;
  assign wr = wr_valid && wr_ready;
  assign rd = rd_valid && rd_ready;

  // storage
  always_ff @(posedge clk) begin
    if (wr) mem[wp] <= wr_data;
  end

  // pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (wr) wp <= (wp == AW'(DEPTH - 1)) ? '0 : wp + AW'(1);
      if (rd) rp <= (rp == AW'(DEPTH - 1)) ? '0 : rp + AW'(1);
      cnt <= cnt + (AW+1)'(wr) - (AW+1)'(rd);
    end
  end

  a_no_over: assert property (@(posedge clk) disable iff (rst)
    cnt <= (AW+1)'(DEPTH))
    else $error("queue overflow");
  a_cnt_track: assert property (@(posedge clk) disable iff (rst)
    (wr && !rd) |=> cnt == $past(cnt) + (AW+1)'(1))
    else $error("queue count slip");
  a_empty_hold: assert property (@(posedge clk) disable iff (rst)
    (cnt == '0 && !wr) |=> cnt == '0)
    else $error("queue count moved while idle");

endmodule

/* rtl/hmt_back.sv */
// ----------------------------------------------------------------------------
// hmt_back
// Takes triangle jobs, works out the normal in a multiply state and a subtract
// state and sends the normal and three vertex records; a count job sends one count record.
// ----------------------------------------------------------------------------
module hmt_back import hmt_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 job_valid,
  output logic                 job_ready,
  input  job_t                 job,
  output logic                 out_valid,
  input  logic                 ready,
  output logic [1:0]           record_kind,
  output logic signed [CW-1:0] coord_x,
  output logic signed [CW-1:0] coord_y,
  output logic signed [CW-1:0] coord_z,
  output logic                 last
);

  localparam logic [2:0] P_IDLE = 3'd0;
  localparam logic [2:0] P_MUL  = 3'd1;
  localparam logic [2:0] P_SUB  = 3'd2;
  localparam logic [2:0] P_EMIT = 3'd3;

  localparam int DW = HW + 1;  // difference width
  localparam int MW = 2 * DW;  // product width

  logic [2:0] state;
  job_t       cur;
  logic [1:0] idx;
  logic       normal_sent;

  // edge vectors
  logic signed [DW-1:0] ux, uy, uz, vx, vy, vz;
  logic signed [MW-1:0] p0, p1, p2, p3, p4, p5;
  logic signed [CW-1:0] nx, ny, nz;

  // output register holding one record
  logic out_free;
  assign out_free = !out_valid || ready;

  assign job_ready = (state == P_IDLE);

  vtx_t vsel;
  always_comb begin
    case (idx)
      2'd0:    vsel = cur.a;
      2'd1:    vsel = cur.b;
      default: vsel = cur.c;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= P_IDLE;
      out_valid   <= 1'b0;
      idx         <= '0;
      normal_sent <= 1'b0;
    end else begin
      // a record leaves; the emit state refills the register itself
      if (out_valid && ready && state != P_EMIT) out_valid <= 1'b0;
      case (state)
        P_IDLE: begin
          if (job_valid) begin
            cur <= job;
            ux <= DW'(job.b.x) - DW'(job.a.x);
            uy <= DW'(job.b.y) - DW'(job.a.y);
            uz <= DW'(job.b.z) - DW'(job.a.z);
            vx <= DW'(job.c.x) - DW'(job.a.x);
            vy <= DW'(job.c.y) - DW'(job.a.y);
            vz <= DW'(job.c.z) - DW'(job.a.z);
            state <= job.is_count ? P_EMIT : P_MUL;
          end
        end
        P_MUL: begin
          p0 <= uy * vz;
          p1 <= uz * vy;
          p2 <= uz * vx;
          p3 <= ux * vz;
          p4 <= ux * vy;
          p5 <= uy * vx;
          state <= P_SUB;
        end
        P_SUB: begin
          nx <= CW'(p0 - p1);
          ny <= CW'(p2 - p3);
          nz <= CW'((p4 - p5) <<< 8);
          idx   <= '0;
          state <= P_EMIT;
        end
        P_EMIT: begin
          if (out_free) begin
            out_valid <= 1'b1;
            if (cur.is_count) begin
              record_kind <= KIND_COUNT;
              coord_x     <= CW'(cur.count);
              coord_y     <= '0;
              coord_z     <= '0;
              last        <= cur.last;
              state       <= P_IDLE;
            end else begin
              if (idx == 2'd0 && !normal_sent) begin
                record_kind <= KIND_NORMAL;
                coord_x     <= nx;
                coord_y     <= ny;
                coord_z     <= nz;
                last        <= 1'b0;
                normal_sent <= 1'b1;
              end else begin
                record_kind <= KIND_VERTEX;
                coord_x     <= CW'(vsel.x);
                coord_y     <= CW'(vsel.y);
                coord_z     <= CW'(vsel.z);
                last        <= cur.last && (idx == 2'd2);
                idx         <= idx + 2'd1;
                if (idx == 2'd2) begin
                  state       <= P_IDLE;
                  normal_sent <= 1'b0;
                end
              end
            end
          end
        end
        default: state <= P_IDLE;
      endcase
    end
  end

  a_kind_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (record_kind == KIND_NORMAL || record_kind == KIND_VERTEX ||
                   record_kind == KIND_COUNT))
    else $error("bad record kind");
  a_take_idle: assert property (@(posedge clk) disable iff (rst)
    (job_valid && job_ready) |=> state != P_IDLE)
    else $error("job taken without starting");
  a_count_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && record_kind == KIND_COUNT) |-> last)
    else $error("count record not last");

endmodule
